// File: hdl/dtu_pkg.sv
`default_nettype none

package dtu_pkg;

  localparam int unsigned HOST_W     = 63;
  localparam int unsigned DEV_W      = 32;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned WRAP_W     = 31;
  localparam int unsigned NS_W       = 64;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  // sample_lag_us * 1000 stays below 2^42
  localparam int unsigned DELAY_NS_W = 42;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic [WRAP_W-1:0] WRAP_MAX = '1;

  localparam logic [CFG_W-1:0] RST_MAX_STEP_US   = 32'd5_000_000;
  localparam logic [CFG_W-1:0] RST_MAX_DRIFT_NS  = 32'd250_000_000;
  localparam logic [CFG_W-1:0] RST_MAX_PAST_NS   = 32'd1_000_000_000;
  localparam logic [CFG_W-1:0] RST_MAX_FUTURE_NS = 32'd50_000_000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEP   = 2'd0,
    CFG_MAX_DRIFT  = 2'd1,
    CFG_MAX_PAST   = 2'd2,
    CFG_MAX_FUTURE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [HOST_W-1:0]  host_time_ns;
    logic               device_time_valid;
    logic [DEV_W-1:0]   device_time_us;
    logic               delay_valid;
    logic [DELAY_W-1:0] sample_lag_us;
  } in_word_t;

  typedef struct packed {
    logic signed [NS_W-1:0] mapped_time_ns;
    logic                   used_device_clock;
    logic                   first_anchor;
    logic                   offset_reanchored;
    logic                   wrap_or_reset_seen;
    logic                   implausible_rejected;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_normal_step_us;
    logic [CFG_W-1:0] max_offset_drift_ns;
    logic [CFG_W-1:0] max_past_skew_ns;
    logic [CFG_W-1:0] max_future_skew_ns;
  } cfg_t;

  // classified word handed from the front to the back
  typedef struct packed {
    logic [HOST_W-1:0]     host;
    logic                  dev_valid;
    logic [WRAP_W-1:0]     wrap_hi;
    logic [DEV_W-1:0]      dev_us;
    logic [DELAY_NS_W-1:0] delay_ns;
    logic                  first;
    logic                  wrap_seen;
    logic                  force_anchor;
  } q_entry_t;

  // x * 1000 modulo 2^64, as 1024 - 16 - 8
  function automatic logic [NS_W-1:0] mul_1000(input logic [NS_W-1:0] x);
    mul_1000 = (x << 10) - (x << 4) - (x << 3);
  endfunction

endpackage

`default_nettype wire

// File: hdl/dtu_in_if.sv
`default_nettype none

interface dtu_in_if;
  import dtu_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/dtu_out_if.sv
`default_nettype none

interface dtu_out_if;
  import dtu_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/device_timestamp_unwrap_and_host_map_unit.sv
// Maps sensor packets onto host nanoseconds. Each word on pkt yields exactly one word on res,
// in order. Words with a device stamp extend the 32-bit microsecond counter by a saturating
// wrap count, re-anchor the device-to-host offset on a timeline reset, on offset drift or on
// a past/future skew violation, and report what happened in the flag fields; words without
// one get host time minus the sample delay. Throughput is one word per clock while res is
// ready: the front classifies a word in the cycle it is taken, and the back holds the offset
// loop in a single stage, so the offset of one word is ready for the next. From accept, the
// word lands in the queue at the accepting edge, then passes the offset precompute and the
// result register before res.valid rises. A four-entry queue separates the two sides; with
// res stalled, up to six words wait (four queued, one in each back stage) before pkt.ready
// drops. Write the configuration registers only while no word is in flight.
`default_nettype none

module device_timestamp_unwrap_and_host_map_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  dtu_in_if.sink                                 pkt,
  dtu_out_if.source                              res,
  input  wire logic                              cfg_we,
  input  wire logic [dtu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtu_pkg::CFG_W-1:0]         cfg_data
);
  import dtu_pkg::*;

  cfg_t     cfg;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  // configuration registers; hold between writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_normal_step_us  <= RST_MAX_STEP_US;
      cfg.max_offset_drift_ns <= RST_MAX_DRIFT_NS;
      cfg.max_past_skew_ns    <= RST_MAX_PAST_NS;
      cfg.max_future_skew_ns  <= RST_MAX_FUTURE_NS;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        CFG_MAX_STEP:   cfg.max_normal_step_us  <= cfg_data;
        CFG_MAX_DRIFT:  cfg.max_offset_drift_ns <= cfg_data;
        CFG_MAX_PAST:   cfg.max_past_skew_ns    <= cfg_data;
        CFG_MAX_FUTURE: cfg.max_future_skew_ns  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: unwrap the device counter, flag wraps and timeline resets
  dtu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .max_step_us (cfg.max_normal_step_us),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  // short queue so either side can stall on its own
  dtu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // back: offset tracking, drift and skew checks, result register
  dtu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .res         (res)
  );

  // a host-only word carries no flags
  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.data.used_device_clock |->
      !(res.data.first_anchor || res.data.offset_reanchored ||
        res.data.wrap_or_reset_seen || res.data.implausible_rejected))
    else $error("flags set on a word without device time");

  // first anchoring and skew rejection both recompute the offset
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.data.first_anchor || res.data.implausible_rejected) |->
      res.data.offset_reanchored)
    else $error("anchor event without offset recompute");

  // hold the result word while res is stalled
  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result word changed while stalled");

endmodule

`default_nettype wire

// File: hdl/dtu_front.sv
`default_nettype none

module dtu_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  dtu_in_if.sink                               pkt,
  input  wire logic [dtu_pkg::CFG_W-1:0]       max_step_us,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output dtu_pkg::q_entry_t                    q_wdata
);
  import dtu_pkg::*;

  logic              anchored;
  logic [DEV_W-1:0]  last_dev;
  logic [WRAP_W-1:0] wrap_count;

  logic [DEV_W-1:0]  dev;
  logic [DEV_W-1:0]  last_eff;
  logic [WRAP_W-1:0] wc_eff;
  logic [WRAP_W-1:0] wrap_count_next;
  logic [DEV_W-1:0]  fwd_step;
  logic [DEV_W:0]    back_step;
  logic              first;
  logic              wrap_seen;
  logic              force_anchor;
  logic [NS_W-1:0]   delay_full;

  assign dev = pkt.data.device_time_us;

  // extend the raw counter against the last device stamp
  always_comb begin
    first           = !anchored;
    last_eff        = anchored ? last_dev : dev;
    wc_eff          = anchored ? wrap_count : '0;
    fwd_step        = dev - last_eff;
    back_step       = {1'b1, dev} - {1'b0, last_eff};
    wrap_seen       = 1'b0;
    force_anchor    = first;
    wrap_count_next = wc_eff;
    if (dev >= last_eff) begin
      if (fwd_step > max_step_us) begin
        wrap_count_next = '0;
        wrap_seen       = 1'b1;
        force_anchor    = 1'b1;
      end
    end else if (back_step <= {1'b0, max_step_us}) begin
      if (wc_eff != WRAP_MAX) wrap_count_next = wc_eff + 1'b1;
      wrap_seen = 1'b1;
    end else begin
      wrap_count_next = '0;
      wrap_seen       = 1'b1;
      force_anchor    = 1'b1;
    end
  end

  assign delay_full = mul_1000({{(NS_W-DELAY_W){1'b0}}, pkt.data.sample_lag_us});

  assign pkt.ready = !q_full;
  assign q_push    = pkt.valid && !q_full;

  always_comb begin
    q_wdata.host         = pkt.data.host_time_ns;
    q_wdata.dev_valid    = pkt.data.device_time_valid;
    q_wdata.wrap_hi      = wrap_count_next;
    q_wdata.dev_us       = dev;
    q_wdata.delay_ns     = pkt.data.delay_valid ? delay_full[DELAY_NS_W-1:0] : '0;
    q_wdata.first        = pkt.data.device_time_valid && first;
    q_wdata.wrap_seen    = pkt.data.device_time_valid && wrap_seen;
    q_wdata.force_anchor = pkt.data.device_time_valid && force_anchor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchored   <= 1'b0;
      last_dev   <= '0;
      wrap_count <= '0;
    end else if (q_push && pkt.data.device_time_valid) begin
      anchored   <= 1'b1;
      last_dev   <= dev;
      wrap_count <= wrap_count_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dtu_queue.sv
`default_nettype none

module dtu_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire dtu_pkg::q_entry_t wdata,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output dtu_pkg::q_entry_t      rdata
);
  import dtu_pkg::*;

  q_entry_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/dtu_back.sv
`default_nettype none

module dtu_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtu_pkg::cfg_t     cfg,
  input  wire logic              q_not_empty,
  input  wire dtu_pkg::q_entry_t q_rdata,
  output logic                   q_pop,
  dtu_out_if.source              res
);
  import dtu_pkg::*;

  // stage A: fresh offset F and F + delay
  logic                  a_valid;
  logic [HOST_W-1:0]     a_host;
  logic                  a_dev_valid;
  logic [NS_W-1:0]       a_f;
  logic [NS_W-1:0]       a_g;
  logic [DELAY_NS_W-1:0] a_d;
  logic                  a_first;
  logic                  a_wrap;
  logic                  a_force;

  // stage B: offset loop and result word
  logic                  b_valid;
  out_word_t             b_word;
  logic [NS_W-1:0]       clock_offset;

  logic                  adv_b;
  logic                  adv_a;
  logic [NS_W-1:0]       ext_ns;
  logic [NS_W-1:0]       f_new;

  logic [NS_W-1:0]        e_diff;
  logic [NS_W-1:0]        h_diff;
  logic                   drift_fail;
  logic                   use_f;
  logic                   rej;
  logic                   take_f;
  logic [NS_W-1:0]        hdelta;
  logic signed [NS_W-1:0] drift_pos;
  logic signed [NS_W-1:0] drift_neg;
  logic signed [NS_W-1:0] past_pos;
  logic signed [NS_W-1:0] fut_neg;
  out_word_t              b_word_next;

  assign adv_b = !b_valid || res.ready;
  assign adv_a = !a_valid || adv_b;
  assign q_pop = q_not_empty && adv_a;

  assign ext_ns = mul_1000({1'b0, q_rdata.wrap_hi, q_rdata.dev_us});
  assign f_new  = {1'b0, q_rdata.host} - ext_ns;

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_host      <= q_rdata.host;
      a_dev_valid <= q_rdata.dev_valid;
      a_f         <= f_new;
      a_g         <= f_new + {{(NS_W-DELAY_NS_W){1'b0}}, q_rdata.delay_ns};
      a_d         <= q_rdata.delay_ns;
      a_first     <= q_rdata.first;
      a_wrap      <= q_rdata.wrap_seen;
      a_force     <= q_rdata.force_anchor;
    end
  end

  assign drift_pos = $signed({{(NS_W-CFG_W){1'b0}}, cfg.max_offset_drift_ns});
  assign drift_neg = $signed(NS_W'(0) - {{(NS_W-CFG_W){1'b0}}, cfg.max_offset_drift_ns});
  assign past_pos  = $signed({{(NS_W-CFG_W){1'b0}}, cfg.max_past_skew_ns});
  assign fut_neg   = $signed(NS_W'(0) - {{(NS_W-CFG_W){1'b0}}, cfg.max_future_skew_ns});

  // with the offset at F the lag reduces to the delay; otherwise it is G - offset
  always_comb begin
    e_diff     = a_f - clock_offset;
    h_diff     = a_g - clock_offset;
    drift_fail = !a_force &&
                 (($signed(e_diff) > drift_pos) || ($signed(e_diff) < drift_neg));
    use_f      = a_force || drift_fail;
    if (use_f) begin
      rej = ({{(DELAY_NS_W-CFG_W){1'b0}}, cfg.max_past_skew_ns} < a_d);
    end else begin
      rej = ($signed(h_diff) > past_pos) || ($signed(h_diff) < fut_neg);
    end
    take_f = use_f || rej;
    if (!a_dev_valid || take_f) begin
      hdelta = {{(NS_W-DELAY_NS_W){1'b0}}, a_d};
    end else begin
      hdelta = h_diff;
    end
    b_word_next.mapped_time_ns       = $signed({1'b0, a_host} - hdelta);
    b_word_next.used_device_clock    = a_dev_valid;
    b_word_next.first_anchor         = a_dev_valid && a_first;
    b_word_next.offset_reanchored    = a_dev_valid && (take_f || a_first);
    b_word_next.wrap_or_reset_seen   = a_dev_valid && a_wrap;
    b_word_next.implausible_rejected = a_dev_valid && rej;
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_valid) b_word <= b_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      clock_offset <= '0;
    end else begin
      if (adv_a) a_valid <= q_not_empty;
      if (adv_b) b_valid <= a_valid;
      if (adv_b && a_valid && a_dev_valid && take_f) clock_offset <= a_f;
    end
  end

  assign res.valid = b_valid;
  assign res.data  = b_word;

endmodule

`default_nettype wire

// File: dv/tb_device_timestamp_unwrap_and_host_map_unit.sv
`default_nettype none

module tb_device_timestamp_unwrap_and_host_map_unit;
  import dtu_pkg::*;

  localparam logic [NS_W-1:0] NS_PER_US = 64'd1000;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 215;
  localparam int MAX_REPORTS = 40;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dtu_in_if  pkt_if ();
  dtu_out_if res_if ();

  device_timestamp_unwrap_and_host_map_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Words waiting to go out on pkt, and mapped stamps waiting to come back on res.
  in_word_t  packets_to_send[$];
  out_word_t stamps_due[$];

  // Mirror of the block: limits and the unwrap/offset state.
  cfg_t            limits;
  logic            dev_anchored;
  logic [DEV_W-1:0] dev_last_us;
  logic [WRAP_W-1:0] dev_wraps;
  logic [NS_W-1:0]  dev_offset_ns;

  // Sensor stream generator: host clock and free-running device counter.
  logic [HOST_W-1:0] gen_host;
  logic [DEV_W-1:0]  gen_dev;

  int unsigned idle_pct = 10;
  int unsigned send_gap = 0;
  int unsigned hold_gap = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Map one packet onto host nanoseconds and advance the mirrored state.
  function automatic out_word_t map_packet(input in_word_t w);
    out_word_t r;
    logic [NS_W-1:0] host;
    logic [NS_W-1:0] ext;
    logic [NS_W-1:0] fresh;
    logic [NS_W-1:0] diff;
    logic [NS_W-1:0] mag;
    logic [NS_W-1:0] sample_us;
    logic [NS_W-1:0] hdelta;
    logic [NS_W-1:0] future_floor;
    logic [DEV_W:0]  back_step;
    r = '0;
    host = {1'b0, w.host_time_ns};
    // No device stamp: host time minus the delay; leave the state alone.
    if (!w.device_time_valid) begin
      r.mapped_time_ns = host - (w.delay_valid ? {32'b0, w.sample_lag_us} * NS_PER_US : '0);
      return r;
    end
    r.used_device_clock = 1'b1;
    if (!dev_anchored) begin
      dev_wraps = '0;
      dev_last_us = w.device_time_us;
      dev_offset_ns = host - {32'b0, w.device_time_us} * NS_PER_US;
      dev_anchored = 1'b1;
      r.offset_reanchored = 1'b1;
      r.first_anchor = 1'b1;
    end
    // Unwrap: a short forward step is continuous, a short backward step is a wrap,
    // anything else restarts the device timeline.
    back_step = {1'b1, w.device_time_us} - {1'b0, dev_last_us};
    if (w.device_time_us >= dev_last_us) begin
      if (w.device_time_us - dev_last_us > limits.max_normal_step_us) begin
        dev_wraps = '0;
        r.wrap_or_reset_seen = 1'b1;
        dev_offset_ns = host - {32'b0, w.device_time_us} * NS_PER_US;
        r.offset_reanchored = 1'b1;
      end
    end else if (back_step <= {1'b0, limits.max_normal_step_us}) begin
      if (dev_wraps != WRAP_MAX) dev_wraps = dev_wraps + 1'b1;
      r.wrap_or_reset_seen = 1'b1;
    end else begin
      dev_wraps = '0;
      r.wrap_or_reset_seen = 1'b1;
      dev_offset_ns = host - {32'b0, w.device_time_us} * NS_PER_US;
      r.offset_reanchored = 1'b1;
    end
    ext = {1'b0, dev_wraps, w.device_time_us};
    fresh = host - ext * NS_PER_US;
    // Drift: the most negative difference negates to itself, which reads as 2^63.
    diff = fresh - dev_offset_ns;
    mag = diff[NS_W-1] ? -diff : diff;
    if (mag > {32'b0, limits.max_offset_drift_ns}) begin
      dev_offset_ns = fresh;
      r.offset_reanchored = 1'b1;
    end
    sample_us = ext - (w.delay_valid ? {32'b0, w.sample_lag_us} : '0);
    r.mapped_time_ns = sample_us * NS_PER_US + dev_offset_ns;
    // Skew: reject a stamp too far behind or ahead of host time, then re-anchor.
    hdelta = host - r.mapped_time_ns;
    future_floor = '0 - {32'b0, limits.max_future_skew_ns};
    if ($signed(hdelta) > $signed({32'b0, limits.max_past_skew_ns}) ||
        $signed(hdelta) < $signed(future_floor)) begin
      r.implausible_rejected = 1'b1;
      dev_offset_ns = fresh;
      r.offset_reanchored = 1'b1;
      r.mapped_time_ns = sample_us * NS_PER_US + dev_offset_ns;
    end
    dev_last_us = w.device_time_us;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic queue_packet(input logic [HOST_W-1:0] host, input logic dv,
                              input logic [DEV_W-1:0] dev, input logic dlv,
                              input logic [DELAY_W-1:0] delay);
    in_word_t w;
    w.host_time_ns = host;
    w.device_time_valid = dv;
    w.device_time_us = dev;
    w.delay_valid = dlv;
    w.sample_lag_us = delay;
    packets_to_send.push_back(w);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MAX_STEP:   limits.max_normal_step_us = val;
      CFG_MAX_DRIFT:  limits.max_offset_drift_ns = val;
      CFG_MAX_PAST:   limits.max_past_skew_ns = val;
      CFG_MAX_FUTURE: limits.max_future_skew_ns = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] drift,
                            input logic [CFG_W-1:0] past, input logic [CFG_W-1:0] future);
    write_reg(CFG_MAX_STEP, step);
    write_reg(CFG_MAX_DRIFT, drift);
    write_reg(CFG_MAX_PAST, past);
    write_reg(CFG_MAX_FUTURE, future);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word has been taken and every stamp has come back.
  task automatic drain();
    while (packets_to_send.size() != 0 || pkt_if.valid || stamps_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly a live sensor stream with jitter, wraps and timeline restarts; the rest noise.
  task automatic feed_stream(input int count);
    in_word_t w;
    int unsigned kind;
    int unsigned dt;
    longint jit;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      w = '0;
      w.delay_valid = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0:       w.sample_lag_us = $urandom;
        1, 2:    w.sample_lag_us = $urandom_range(0, 2_000_000);
        default: w.sample_lag_us = $urandom_range(0, 50_000);
      endcase
      if (kind < 8) begin
        w.host_time_ns = 63'({$urandom, $urandom});
        w.device_time_valid = 1'($urandom_range(0, 1));
        w.device_time_us = $urandom;
      end else begin
        // Park the counter just below its top so that wraps follow soon.
        if (kind < 12) gen_dev = 32'hFFFF_FFFF - $urandom_range(0, 300_000);
        else if (kind < 15) gen_dev = $urandom;
        case ($urandom_range(0, 19))
          0:       dt = limits.max_normal_step_us + 1;
          1, 2:    dt = $urandom_range(0, limits.max_normal_step_us);
          default: dt = $urandom_range(0, 20_000);
        endcase
        case ($urandom_range(0, 9))
          0:       jit = longint'($urandom_range(0, 600_000_000)) - 300_000_000;
          1:       jit = longint'($urandom_range(0, 160_000_000)) - 80_000_000;
          default: jit = longint'($urandom_range(0, 2_000_000)) - 1_000_000;
        endcase
        gen_dev = gen_dev + dt;
        gen_host = gen_host + 63'(longint'(dt) * 1000 + jit);
        w.host_time_ns = gen_host;
        w.device_time_valid = !(kind >= 15 && kind < 22);
        w.device_time_us = gen_dev;
      end
      packets_to_send.push_back(w);
    end
  endtask

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive pkt from the pending queue; predict each word as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      pkt_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pkt_if.valid && pkt_if.ready) stamps_due.push_back(map_packet(pkt_if.data));
      // Hold the word while it waits for ready; pick the next one otherwise.
      if (!pkt_if.valid || pkt_if.ready) begin
        if (send_gap == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          send_gap = $urandom_range(1, 15);
        if (send_gap != 0) begin
          send_gap--;
          pkt_if.valid <= 1'b0;
        end else if (packets_to_send.size() != 0) begin
          pkt_if.valid <= 1'b1;
          pkt_if.data <= packets_to_send.pop_front();
        end else begin
          pkt_if.valid <= 1'b0;
        end
      end
    end
  end

  // Take res words, stall in bursts, and compare against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    out_word_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (stamps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result word with none expected: expected nothing, actual %h",
                     $time, res_if.data);
        end else begin
          want = stamps_due.pop_front();
          check_field("mapped_time_ns", want.mapped_time_ns, res_if.data.mapped_time_ns);
          check_field("used_device_clock", want.used_device_clock,
                      res_if.data.used_device_clock);
          check_field("first_anchor", want.first_anchor, res_if.data.first_anchor);
          check_field("offset_reanchored", want.offset_reanchored,
                      res_if.data.offset_reanchored);
          check_field("wrap_or_reset_seen", want.wrap_or_reset_seen,
                      res_if.data.wrap_or_reset_seen);
          check_field("implausible_rejected", want.implausible_rejected,
                      res_if.data.implausible_rejected);
        end
      end
      if (hold_gap == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        hold_gap = $urandom_range(1, 15);
      if (hold_gap != 0) begin
        hold_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [HOST_W-1:0] hb;
    logic [DEV_W-1:0]  dv;
    rst = 1'b1;
    pkt_if.valid = 1'b0;
    pkt_if.data = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_STEP;
    cfg_data = '0;
    limits.max_normal_step_us = RST_MAX_STEP_US;
    limits.max_offset_drift_ns = RST_MAX_DRIFT_NS;
    limits.max_past_skew_ns = RST_MAX_PAST_NS;
    limits.max_future_skew_ns = RST_MAX_FUTURE_NS;
    dev_anchored = 1'b0;
    dev_last_us = '0;
    dev_wraps = '0;
    dev_offset_ns = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words, run under the reset limits.
    // Host-only words: full delay, a stamp below zero, plain host time.
    queue_packet('1, 1'b0, '0, 1'b1, '1);
    queue_packet('0, 1'b0, '1, 1'b1, '1);
    queue_packet('1, 1'b0, '0, 1'b0, '0);
    // First anchor near the top of host time, then host back at zero one us later:
    // the offset difference lands on the most negative value.
    queue_packet(63'h7FFF_FFFF_FFFF_FC18, 1'b1, 32'd0, 1'b0, '0);
    queue_packet('0, 1'b1, 32'd1, 1'b0, '0);
    // Huge forward jump with full delay: timeline restart plus a stamp far in the past.
    queue_packet('1, 1'b1, '1, 1'b1, '1);
    hb = 63'd1_000_000_000_000;
    // Short step across the top: a counter wrap.
    queue_packet(hb, 1'b1, 32'd5, 1'b0, '0);
    // Long step backward: a restart.
    queue_packet(hb, 1'b1, 32'd0, 1'b0, '0);
    // Forward step exactly at the continuous limit, then one past it.
    hb = hb + 63'd5_000_000_000;
    queue_packet(hb, 1'b1, 32'd5_000_000, 1'b0, '0);
    hb = hb + 63'd5_000_001_000;
    dv = 32'd10_000_001;
    queue_packet(hb, 1'b1, dv, 1'b0, '0);
    // Two seconds of delay: past skew violated; then exactly one second: accepted.
    dv = dv + 100;
    hb = hb + 63'd100_000;
    queue_packet(hb, 1'b1, dv, 1'b1, 32'd2_000_000);
    dv = dv + 100;
    hb = hb + 63'd100_000;
    queue_packet(hb, 1'b1, dv, 1'b1, 32'd1_000_000);
    // Host 60 ms early: future skew violated; then exactly 50 ms early: accepted.
    dv = dv + 100;
    hb = hb + 63'd100_000 - 63'd60_000_000;
    queue_packet(hb, 1'b1, dv, 1'b0, '0);
    dv = dv + 100;
    hb = hb + 63'd100_000 - 63'd50_000_000;
    queue_packet(hb, 1'b1, dv, 1'b0, '0);
    // Drift exactly at the limit, then one ns past it.
    dv = dv + 100;
    hb = hb + 63'd100_000 + 63'd300_000_000;
    queue_packet(hb, 1'b1, dv, 1'b0, '0);
    dv = dv + 100;
    hb = hb + 63'd100_001;
    queue_packet(hb, 1'b1, dv, 1'b0, '0);
    // Delay field ignored when not flagged; zero delay when flagged.
    dv = dv + 100;
    hb = hb + 63'd100_000;
    queue_packet(hb, 1'b1, dv, 1'b0, '1);
    dv = dv + 100;
    hb = hb + 63'd100_000;
    queue_packet(hb, 1'b1, dv, 1'b1, '0);

    gen_host = 63'({$urandom, $urandom} >> 2);
    gen_dev = $urandom;
    feed_stream(WORDS_PER_PHASE);

    // Each later phase: drain, rewrite the limits, run another stream.
    for (int p = 1; p < PHASES; p++) begin
      drain();
      idle_pct = $urandom_range(2, 12);
      case (p)
        1: set_limits('0, '0, '0, '0);
        2: set_limits('1, '1, '1, '1);
        3: set_limits($urandom_range(1_000, 20_000_000), $urandom_range(0, 500_000_000),
                      $urandom_range(0, 2_000_000_000), $urandom_range(0, 200_000_000));
        4: set_limits($urandom_range(100, 100_000), $urandom, $urandom, $urandom);
        default: begin
          // Last stretch at full rate on both sides.
          idle_pct = 0;
          set_limits(RST_MAX_STEP_US, RST_MAX_DRIFT_NS, RST_MAX_PAST_NS, RST_MAX_FUTURE_NS);
        end
      endcase
      @(negedge clk);
      feed_stream(WORDS_PER_PHASE);
    end

    drain();
    // Give a stray word time to show up.
    repeat (8) @(negedge clk);
    if (mismatches == 0 && stamps_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
